FILE: hw/rtl/wpcc_pkg.sv
`default_nettype none

package wpcc_pkg;

	localparam int FIELD_W = 10;
	localparam int OCC_W = 11;
	localparam int CFG_W = 4;
	localparam int MAX_VARS_DEFAULT = 10;

	// The bitmap is stored as words of 2**WORD_LG bits.
	localparam int WORD_LG = 5;
	localparam int WORD_W = 1 << WORD_LG;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic command;
		logic [FIELD_W-1:0] fixed_bits;
		logic [FIELD_W-1:0] wildcard_mask;
	} in_item_t;

	typedef struct packed {
		logic accepted;
		logic [OCC_W-1:0] occupied_count;
	} out_item_t;

	typedef logic [CFG_W-1:0] cfg_word_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wpcc_stream_if.sv
`default_nettype none

interface wpcc_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wpcc_ram.sv
`default_nettype none

module wpcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wildcard_pattern_coverage_checker.sv
// Coverage checker for wildcard patterns over up to MAX_VARS boolean variables. An insert item
// is expanded into every combination it covers, lowest wildcard varying slowest and 0 before 1;
// each combination is tested and marked in a bitmap held in a word-wide RAM, one combination per
// cycle in a read-modify-write pipeline with forwarding. The first combination already marked
// ends the walk with accepted low, keeping the marks made before it. With var_count zero an
// insert is rejected without a walk. A clear item sweeps the RAM one word per cycle,
// 2**(MAX_VARS-5) words (32 at ten variables, never fewer than two). The same sweep runs
// after reset before the first item is taken. The var_count register may be written at any
// time the block is idle and takes effect at once.
`default_nettype none

module wildcard_pattern_coverage_checker
	import wpcc_pkg::*;
#(
	parameter int MAX_VARS = MAX_VARS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	wpcc_stream_if.sink cfg,
	wpcc_stream_if.sink cmd,
	wpcc_stream_if.source result
);
	localparam int ADDR_W = (MAX_VARS > WORD_LG) ? MAX_VARS - WORD_LG : 1;
	localparam int CMB_W = ADDR_W + WORD_LG;
	localparam int DEPTH = 1 << ADDR_W;

	state_t state_q, state_d;
	cfg_word_t var_count_q;

	logic [MAX_VARS-1:0] base_q, rwild_q, rsub_q;
	logic more_q;
	logic rd_s1, last_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [WORD_LG-1:0] bit_s1;
	logic fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [WORD_W-1:0] fwd_word_q;
	logic [OCC_W-1:0] count_q;
	logic acc_q;
	logic clear_cmd_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic result_valid_q;
	out_item_t res_q;

	logic [MAX_VARS-1:0] vmask, wild_in, base_in, rwild_in, rsub_rev, combo, rsub_next;
	logic [CMB_W-1:0] issue_cmb;
	logic issue_last, issue;
	logic [WORD_W-1:0] ram_rdata, cur_word, set_word;
	logic cur_bit, walk_hit, walk_mark, walk_end;
	logic cmd_acc, load_result;
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata;

	assign cmd_acc = cmd.valid && cmd.ready;

	// Pattern preparation; positions at or above var_count are dropped.
	always_comb begin
		for (int i = 0; i < MAX_VARS; i++) begin
			vmask[i] = (i < int'(var_count_q));
		end
		wild_in = MAX_VARS'(cmd.payload.wildcard_mask) & vmask;
		base_in = MAX_VARS'(cmd.payload.fixed_bits) & vmask & ~wild_in;
		for (int i = 0; i < MAX_VARS; i++) begin
			rwild_in[i] = wild_in[MAX_VARS-1-i];
		end
	end

	// The wildcard counter runs bit-reversed so that an ordinary submask increment makes
	// the highest wildcard position the fastest one.
	always_comb begin
		for (int i = 0; i < MAX_VARS; i++) begin
			rsub_rev[i] = rsub_q[MAX_VARS-1-i];
		end
		combo = base_q | rsub_rev;
		issue_cmb = CMB_W'(combo);
		rsub_next = ((rsub_q | ~rwild_q) + MAX_VARS'(1)) & rwild_q;
		issue_last = (rsub_q == rwild_q);
	end

	always_comb begin
		cur_word = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_word_q : ram_rdata;
		cur_bit = cur_word[bit_s1];
		set_word = cur_word | (WORD_W'(1) << bit_s1);
		walk_hit = (state_q == ST_WALK) && rd_s1 && cur_bit;
		walk_mark = (state_q == ST_WALK) && rd_s1 && !cur_bit;
		walk_end = walk_hit || (walk_mark && last_s1);
		issue = (state_q == ST_WALK) && more_q && !walk_hit;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_addr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = clear_cmd_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					if (cmd.payload.command == CMD_CLEAR) begin
						state_d = ST_SWEEP;
					end else if (var_count_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!result_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = set_word;
		load_result = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				ram_we = 1'b1;
				ram_waddr = sweep_addr_q;
				ram_wdata = '0;
			end
			ST_WALK: begin
				ram_we = walk_mark;
			end
			ST_FINISH: begin
				load_result = !result_valid_q || result.ready;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_raddr = issue_cmb[CMB_W-1:WORD_LG];
	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign result.valid = result_valid_q;
	assign result.payload = res_q;

	wpcc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_map (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			var_count_q <= '0;
			count_q <= '0;
			clear_cmd_q <= 1'b0;
			sweep_addr_q <= '0;
			more_q <= 1'b0;
			rd_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				var_count_q <= cfg.payload;
			end
			if (cmd_acc && (cmd.payload.command == CMD_CLEAR)) begin
				count_q <= '0;
			end else if (walk_mark) begin
				count_q <= count_q + OCC_W'(1);
			end
			if (cmd_acc) begin
				clear_cmd_q <= (cmd.payload.command == CMD_CLEAR);
			end
			if (state_q == ST_SWEEP) begin
				sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
			end
			if (cmd_acc) begin
				more_q <= (cmd.payload.command == CMD_INSERT);
			end else if (walk_end || (issue && issue_last)) begin
				more_q <= 1'b0;
			end
			rd_s1 <= issue;
			fwd_valid_q <= walk_mark;
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result.ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			base_q <= base_in;
			rwild_q <= rwild_in;
			rsub_q <= '0;
			acc_q <= (cmd.payload.command == CMD_CLEAR);
		end else begin
			if (issue) begin
				rsub_q <= rsub_next;
			end
			if (walk_hit) begin
				acc_q <= 1'b0;
			end else if (walk_mark && last_s1) begin
				acc_q <= 1'b1;
			end
		end
		if (issue) begin
			addr_s1 <= issue_cmb[CMB_W-1:WORD_LG];
			bit_s1 <= issue_cmb[WORD_LG-1:0];
			last_s1 <= issue_last;
		end
		if (walk_mark) begin
			fwd_addr_q <= addr_s1;
			fwd_word_q <= set_word;
		end
		if (load_result) begin
			res_q.accepted <= acc_q;
			res_q.occupied_count <= count_q;
		end
	end

	a_sweep_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (count_q == '0))
		else $error("occupied count is not zero during a map sweep");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (state_q == ST_WALK))
		else $error("bitmap read pending outside of a walk");

	a_idle_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && !cmd.valid) |=> $stable(count_q))
		else $error("occupied count changed with no item in progress");

	a_finish_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && (!result_valid_q || result.ready))
		|=> (result_valid_q && (state_q == ST_IDLE)))
		else $error("finished item was not moved to the result register");

endmodule

`default_nettype wire

FILE: sim/wildcard_pattern_coverage_checker_tb.sv
`timescale 1ns / 1ps

module wildcard_pattern_coverage_checker_tb;
	import wpcc_pkg::*;

	localparam int MAX_VARS = MAX_VARS_DEFAULT;
	localparam int MAP_SIZE = 1 << MAX_VARS;
	localparam logic [FIELD_W-1:0] ALL_BITS = '1;

	logic clk = 1'b0;
	logic arst_n;

	wpcc_stream_if #(.payload_t(cfg_word_t)) cfg_if ();
	wpcc_stream_if #(.payload_t(in_item_t)) cmd_if ();
	wpcc_stream_if #(.payload_t(out_item_t)) res_if ();

	wildcard_pattern_coverage_checker #(
		.MAX_VARS(MAX_VARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.cmd(cmd_if),
		.result(res_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the block's state, advanced as each item is accepted.
	bit seen_map [MAP_SIZE];
	logic [OCC_W-1:0] marked_cnt;
	cfg_word_t var_count_reg;

	out_item_t verdict_q [$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	function automatic out_item_t mark_pattern(in_item_t it);
		int nv;
		int nw;
		int j;
		int unsigned k;
		int wild_pos [MAX_VARS];
		logic [FIELD_W-1:0] active;
		logic [FIELD_W-1:0] base;
		logic [FIELD_W-1:0] combo;
		bit ok;
		out_item_t r;
		nv = (var_count_reg > MAX_VARS) ? MAX_VARS : int'(var_count_reg);
		ok = 1'b1;
		nw = 0;
		active = '0;
		if (it.command == CMD_CLEAR) begin
			seen_map = '{default: 1'b0};
			marked_cnt = '0;
		end else if (nv == 0) begin
			ok = 1'b0;
		end else begin
			for (j = 0; j < nv; j++) begin
				active[j] = 1'b1;
				if (it.wildcard_mask[j]) begin
					wild_pos[nw] = j;
					nw++;
				end
			end
			base = it.fixed_bits & active & ~it.wildcard_mask;
			// The lowest wildcard is the most significant digit of the walk counter.
			for (k = 0; k < (1 << nw) && ok; k++) begin
				combo = base;
				for (j = 0; j < nw; j++)
					if ((k >> (nw - 1 - j)) & 1)
						combo[wild_pos[j]] = 1'b1;
				if (seen_map[combo]) begin
					ok = 1'b0;
				end else begin
					seen_map[combo] = 1'b1;
					marked_cnt++;
				end
			end
		end
		r.accepted = ok;
		r.occupied_count = marked_cnt;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_verdict(out_item_t got);
		out_item_t want;
		if (verdict_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending (accepted %0b count %0d)",
				got.accepted, got.occupied_count));
		end else begin
			want = verdict_q.pop_front();
			if (got.accepted !== want.accepted)
				report_mismatch($sformatf("accepted is %0b, predicted %0b",
					got.accepted, want.accepted));
			if (got.occupied_count !== want.occupied_count)
				report_mismatch($sformatf("occupied_count is %0d, predicted %0d",
					got.occupied_count, want.occupied_count));
		end
	endtask

	// Result side: checks every handshake and drives ready with random or forced stalls.
	always @(posedge clk) begin
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
			check_verdict(res_if.payload);
		if (hold_cycles > 0) begin
			res_if.ready <= 1'b0;
			hold_cycles--;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.payload <= it;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		verdict_q.push_back(mark_pattern(it));
	endtask

	task automatic send_pattern(logic [FIELD_W-1:0] fixed, logic [FIELD_W-1:0] wild);
		in_item_t it;
		it.command = CMD_INSERT;
		it.fixed_bits = fixed;
		it.wildcard_mask = wild;
		send_item(it);
	endtask

	task automatic send_clear();
		in_item_t it;
		it.command = CMD_CLEAR;
		it.fixed_bits = FIELD_W'($urandom_range(1023));
		it.wildcard_mask = FIELD_W'($urandom_range(1023));
		send_item(it);
	endtask

	task automatic wait_for_verdicts();
		cmd_if.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_var_count(cfg_word_t vc);
		wait_for_verdicts();
		cfg_if.valid <= 1'b1;
		cfg_if.payload <= vc;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		var_count_reg = vc;
	endtask

	function automatic in_item_t random_pattern();
		in_item_t it;
		int pick;
		int nw;
		it.command = ($urandom_range(99) < 6) ? CMD_CLEAR : CMD_INSERT;
		it.fixed_bits = FIELD_W'($urandom_range(1023));
		// Mostly few wildcards, so the walks stay short and duplicates stay likely.
		pick = $urandom_range(99);
		if (pick < 70)
			nw = $urandom_range(3);
		else if (pick < 95)
			nw = $urandom_range(6, 4);
		else
			nw = $urandom_range(10, 7);
		it.wildcard_mask = '0;
		repeat (nw) it.wildcard_mask[$urandom_range(FIELD_W - 1)] = 1'b1;
		return it;
	endfunction

	task automatic run_random_phase(cfg_word_t vc, int n_items);
		set_var_count(vc);
		repeat (n_items) send_item(random_pattern());
	endtask

	task automatic test_zero_vars();
		send_pattern(ALL_BITS, ALL_BITS);
		send_pattern('0, '0);
		send_clear();
	endtask

	task automatic test_full_space();
		set_var_count(4'd10);
		send_pattern('0, ALL_BITS);
		send_pattern(10'h155, '0);
		send_clear();
	endtask

	task automatic test_walk_order();
		send_pattern(10'h001, '0);
		// Marks 0 and 2 before it reaches 1, which is already taken.
		send_pattern('0, 10'h003);
		send_pattern(ALL_BITS, 10'h300);
		send_pattern(ALL_BITS, '0);
	endtask

	task automatic test_narrow_vars();
		set_var_count(4'd1);
		send_clear();
		send_pattern(10'h3fe, 10'h3fe);
		send_pattern(10'h001, 10'h3fe);
		send_pattern('0, 10'h001);
	endtask

	task automatic test_vars_above_max();
		set_var_count(4'd15);
		send_clear();
		send_pattern(10'h200, '0);
		send_pattern(ALL_BITS, ALL_BITS);
	endtask

	task automatic test_backpressure();
		set_var_count(4'd10);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_clear();
		hold_cycles = 300;
		repeat (24) send_pattern(FIELD_W'($urandom_range(1023)), 10'(1 << $urandom_range(9)));
		wait_for_verdicts();
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 16;
		recv_idle_pct = 77;
		run_random_phase(4'd10, 120);
		run_random_phase(4'd4, 60);
		run_random_phase(4'd15, 60);
		send_idle_pct = 77;
		recv_idle_pct = 16;
		run_random_phase(4'd7, 80);
		run_random_phase(4'd1, 40);
		run_random_phase(4'd10, 120);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(4'd0, 30);
		run_random_phase(4'd9, 80);
		run_random_phase(cfg_word_t'($urandom_range(15, 1)), 60);
		run_random_phase(4'd10, 150);
		run_random_phase(4'd2, 50);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		cmd_if.valid = 1'b0;
		cmd_if.payload = '0;
		res_if.ready = 1'b0;
		seen_map = '{default: 1'b0};
		marked_cnt = '0;
		var_count_reg = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 16;
		recv_idle_pct = 77;
		test_zero_vars();
		test_full_space();
		test_walk_order();
		test_narrow_vars();
		test_vars_above_max();
		test_backpressure();
		test_random_traffic();
		wait_for_verdicts();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
